// ===== design/bcs_pkg.sv =====
// Shared types and constants for the Bezier curve splitter.
// No dependencies; used by every module of the block.
`default_nettype none

package bcs_pkg;

  // Number of control points the emitter holds for one split curve.
  localparam int unsigned NUM_SEQ = 7;

  // Index of the final emitted point for each curve order.
  localparam logic [2:0] LAST_IDX_QUAD  = 3'd4;
  localparam logic [2:0] LAST_IDX_CUBIC = 3'd6;

  // Curve order codes as carried on the func input.
  localparam logic FUNC_QUAD  = 1'b0;
  localparam logic FUNC_CUBIC = 1'b1;

  // Valid flag and curve order passed along each internal link.
  typedef struct packed {
    logic valid;
    logic cubic;
  } bcs_link_t;

  // Sequencer states of the subdivision engine.
  typedef enum logic [1:0] {
    ENG_IDLE,
    ENG_MUL,
    ENG_ADD,
    ENG_DONE
  } bcs_eng_state_e;

endpackage

`default_nettype wire

// ===== design/bcs_front.sv =====
// Input side of the splitter: saturates t, classifies the curve order and
// buffers the item in a two-entry queue. Depends on bcs_pkg.
`default_nettype none

module bcs_front #(
  parameter int unsigned COORD_WIDTH = 32,
  parameter int unsigned T_FRAC_BITS = 16
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       push,
  output logic                            full,
  input  wire logic                       func_i,
  input  wire logic [T_FRAC_BITS:0]       param_t_i,
  input  wire logic [8*COORD_WIDTH-1:0]   coords_i,
  input  wire logic                       pop_i,
  output bcs_pkg::bcs_link_t              link_o,
  output logic      [T_FRAC_BITS:0]       item_t_o,
  output logic      [8*COORD_WIDTH-1:0]   item_c_o
);

  localparam int unsigned IW = 1 + (T_FRAC_BITS + 1) + 8 * COORD_WIDTH;
  localparam logic [T_FRAC_BITS:0] T_ONE = {1'b1, {T_FRAC_BITS{1'b0}}};

  logic [T_FRAC_BITS:0] t_sat;
  logic                 wr_en;
  logic                 rd_en;
  logic [IW-1:0]        ent_q [2];
  logic                 wr_ptr_q, wr_ptr_d;
  logic                 rd_ptr_q, rd_ptr_d;
  logic [1:0]           cnt_q, cnt_d;
  logic [IW-1:0]        head;

  // Values of t above one are clamped to exactly one.
  always_comb begin
    if (param_t_i[T_FRAC_BITS] && (|param_t_i[T_FRAC_BITS-1:0])) begin
      t_sat = T_ONE;
    end else begin
      t_sat = param_t_i;
    end
  end

  assign full  = (cnt_q == 2'd2);
  assign wr_en = push && !full;
  assign rd_en = pop_i && (cnt_q != 2'd0);

  // Queue pointers and fill count.
  always_comb begin
    wr_ptr_d = wr_en ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = rd_en ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q;
    if (wr_en && !rd_en) begin
      cnt_d = cnt_q + 2'd1;
    end else if (rd_en && !wr_en) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Queue storage, written with the classified transaction.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      ent_q[wr_ptr_q] <= {(func_i == bcs_pkg::FUNC_CUBIC), t_sat, coords_i};
    end
  end

  assign head         = ent_q[rd_ptr_q];
  assign link_o.valid = (cnt_q != 2'd0);
  assign link_o.cubic = head[IW-1];
  assign item_t_o     = head[IW-2 -: (T_FRAC_BITS + 1)];
  assign item_c_o     = head[8*COORD_WIDTH-1:0];

endmodule

`default_nettype wire

// ===== design/bcs_engine.sv =====
// Subdivision engine: runs de Casteljau levels, each as a multiply state followed by
// an add state, and collects the split points. Depends on bcs_pkg.
`default_nettype none

module bcs_engine #(
  parameter int unsigned COORD_WIDTH = 32,
  parameter int unsigned T_FRAC_BITS = 16
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire bcs_pkg::bcs_link_t         in_link_i,
  input  wire logic [T_FRAC_BITS:0]       item_t_i,
  input  wire logic [8*COORD_WIDTH-1:0]   item_c_i,
  output logic                            pop_o,
  output bcs_pkg::bcs_link_t              out_link_o,
  input  wire logic                       out_ready_i,
  output logic      [7*COORD_WIDTH-1:0]   seq_x_o,
  output logic      [7*COORD_WIDTH-1:0]   seq_y_o
);

  localparam int unsigned W  = COORD_WIDTH;
  localparam int unsigned F  = T_FRAC_BITS;
  localparam int unsigned PW = W + F + 3;
  localparam logic signed [PW-1:0] HALF = {{(W + 3){1'b0}}, 1'b1, {(F - 1){1'b0}}};

  bcs_pkg::bcs_eng_state_e state_q, state_d;

  logic signed [W-1:0]  px_q [4];
  logic signed [W-1:0]  py_q [4];
  logic signed [PW-1:0] mx_q [3];
  logic signed [PW-1:0] my_q [3];
  logic signed [W-1:0]  sx_q [7];
  logic signed [W-1:0]  sy_q [7];
  logic signed [W-1:0]  nx   [3];
  logic signed [W-1:0]  ny   [3];
  logic signed [PW-1:0] prod_x [3];
  logic signed [PW-1:0] prod_y [3];
  logic [F:0]           t_q;
  logic                 cubic_q;
  logic [1:0]           lvl_q;
  logic                 last_lvl;
  logic                 load;
  logic                 mul_en;
  logic                 add_en;

  assign last_lvl = cubic_q ? (lvl_q == 2'd3) : (lvl_q == 2'd2);

  // Next state of the level sequencer.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      bcs_pkg::ENG_IDLE: if (in_link_i.valid) state_d = bcs_pkg::ENG_MUL;
      bcs_pkg::ENG_MUL:  state_d = bcs_pkg::ENG_ADD;
      bcs_pkg::ENG_ADD:  state_d = last_lvl ? bcs_pkg::ENG_DONE : bcs_pkg::ENG_MUL;
      bcs_pkg::ENG_DONE: begin
        if (out_ready_i) begin
          state_d = in_link_i.valid ? bcs_pkg::ENG_MUL : bcs_pkg::ENG_IDLE;
        end
      end
      default: state_d = bcs_pkg::ENG_IDLE;
    endcase
  end

  // Strobes decoded from the sequencer state.
  always_comb begin
    load   = 1'b0;
    mul_en = 1'b0;
    add_en = 1'b0;
    unique case (state_q)
      bcs_pkg::ENG_IDLE: load = in_link_i.valid;
      bcs_pkg::ENG_MUL:  mul_en = 1'b1;
      bcs_pkg::ENG_ADD:  add_en = 1'b1;
      bcs_pkg::ENG_DONE: load = out_ready_i && in_link_i.valid;
      default: ;
    endcase
  end

  assign pop_o            = load;
  assign out_link_o.valid = (state_q == bcs_pkg::ENG_DONE);
  assign out_link_o.cubic = cubic_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bcs_pkg::ENG_IDLE;
      lvl_q   <= 2'd0;
    end else begin
      state_q <= state_d;
      if (load) begin
        lvl_q <= 2'd1;
      end else if (add_en && !last_lvl) begin
        lvl_q <= lvl_q + 2'd1;
      end
    end
  end

  // Blend arithmetic: (b - a) * t in the multiply cycle, rounded add after.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      prod_x[i] = ($signed({px_q[i+1][W-1], px_q[i+1]}) - $signed({px_q[i][W-1], px_q[i]}))
                  * $signed({1'b0, t_q});
      prod_y[i] = ($signed({py_q[i+1][W-1], py_q[i+1]}) - $signed({py_q[i][W-1], py_q[i]}))
                  * $signed({1'b0, t_q});
      nx[i] = px_q[i] + W'((mx_q[i] + HALF) >>> F);
      ny[i] = py_q[i] + W'((my_q[i] + HALF) >>> F);
    end
  end

  // Working points, products and the collected split sequence.
  always_ff @(posedge clk_i) begin
    if (load) begin
      t_q     <= item_t_i;
      cubic_q <= in_link_i.cubic;
      for (int i = 0; i < 4; i++) begin
        px_q[i] <= item_c_i[(2*i)*W +: W];
        py_q[i] <= item_c_i[(2*i+1)*W +: W];
      end
      sx_q[0] <= item_c_i[0 +: W];
      sy_q[0] <= item_c_i[W +: W];
      if (in_link_i.cubic) begin
        sx_q[6] <= item_c_i[6*W +: W];
        sy_q[6] <= item_c_i[7*W +: W];
      end else begin
        sx_q[4] <= item_c_i[4*W +: W];
        sy_q[4] <= item_c_i[5*W +: W];
      end
    end
    if (mul_en) begin
      for (int i = 0; i < 3; i++) begin
        mx_q[i] <= prod_x[i];
        my_q[i] <= prod_y[i];
      end
    end
    if (add_en) begin
      for (int i = 0; i < 3; i++) begin
        px_q[i] <= nx[i];
        py_q[i] <= ny[i];
      end
      case (lvl_q)
        2'd1: begin
          sx_q[1] <= nx[0];
          sy_q[1] <= ny[0];
          if (cubic_q) begin
            sx_q[5] <= nx[2];
            sy_q[5] <= ny[2];
          end else begin
            sx_q[3] <= nx[1];
            sy_q[3] <= ny[1];
          end
        end
        2'd2: begin
          sx_q[2] <= nx[0];
          sy_q[2] <= ny[0];
          if (cubic_q) begin
            sx_q[4] <= nx[1];
            sy_q[4] <= ny[1];
          end
        end
        default: begin
          sx_q[3] <= nx[0];
          sy_q[3] <= ny[0];
        end
      endcase
    end
  end

  // Flatten the sequence for the handoff to the emitter.
  always_comb begin
    for (int i = 0; i < 7; i++) begin
      seq_x_o[i*W +: W] = sx_q[i];
      seq_y_o[i*W +: W] = sy_q[i];
    end
  end

endmodule

`default_nettype wire

// ===== design/bcs_emit.sv =====
// Result side of the splitter: holds one finished point sequence and hands
// out one point per pop transaction. Depends on bcs_pkg.
`default_nettype none

module bcs_emit #(
  parameter int unsigned COORD_WIDTH = 32
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire bcs_pkg::bcs_link_t         in_link_i,
  output logic                            ready_o,
  input  wire logic [7*COORD_WIDTH-1:0]   seq_x_i,
  input  wire logic [7*COORD_WIDTH-1:0]   seq_y_i,
  output logic                            empty,
  input  wire logic                       pop,
  output logic signed [COORD_WIDTH-1:0]   out_x_o,
  output logic signed [COORD_WIDTH-1:0]   out_y_o,
  output logic        [2:0]               point_index_o,
  output logic                            last_point_o
);

  localparam int unsigned W = COORD_WIDTH;

  logic [W-1:0] bx_q [bcs_pkg::NUM_SEQ];
  logic [W-1:0] by_q [bcs_pkg::NUM_SEQ];
  logic         busy_q;
  logic         cubic_q;
  logic [2:0]   idx_q;
  logic         take;
  logic         is_last;

  assign is_last = (idx_q == (cubic_q ? bcs_pkg::LAST_IDX_CUBIC : bcs_pkg::LAST_IDX_QUAD));
  assign take    = pop && busy_q;
  // A new sequence may enter when idle or as the final point leaves.
  assign ready_o = !busy_q || (take && is_last);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= 3'd0;
    end else if (in_link_i.valid && ready_o) begin
      busy_q <= 1'b1;
      idx_q  <= 3'd0;
    end else if (take) begin
      busy_q <= !is_last;
      idx_q  <= idx_q + 3'd1;
    end
  end

  // Point bank, loaded whole from the engine.
  always_ff @(posedge clk_i) begin
    if (in_link_i.valid && ready_o) begin
      cubic_q <= in_link_i.cubic;
      for (int i = 0; i < bcs_pkg::NUM_SEQ; i++) begin
        bx_q[i] <= seq_x_i[i*W +: W];
        by_q[i] <= seq_y_i[i*W +: W];
      end
    end
  end

  assign empty         = !busy_q;
  assign out_x_o       = $signed(bx_q[idx_q]);
  assign out_y_o       = $signed(by_q[idx_q]);
  assign point_index_o = idx_q;
  assign last_point_o  = is_last;

endmodule

`default_nettype wire

// ===== design/bezier_curve_split.sv =====
// Bezier curve splitter (de Casteljau subdivision) top level.
// A curve passes the input queue, a multiply and an add state per de Casteljau level in
// the engine, and the result port, which hands out one point per cycle while pop stays
// high; the engine starts the next curve as soon as the result port takes the last one.
// Reset clears the queue, the sequencer and the result counter; no data is cleared.
// Depends on bcs_pkg, bcs_front, bcs_engine and bcs_emit.
`default_nettype none

module bezier_curve_split #(
  parameter int unsigned COORD_WIDTH = 32,
  parameter int unsigned T_FRAC_BITS = 16
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       push,
  output logic                            full,
  input  wire logic                       func_i,
  input  wire logic [T_FRAC_BITS:0]       param_t_i,
  input  wire logic signed [COORD_WIDTH-1:0] ctrl0_x_i,
  input  wire logic signed [COORD_WIDTH-1:0] ctrl0_y_i,
  input  wire logic signed [COORD_WIDTH-1:0] ctrl1_x_i,
  input  wire logic signed [COORD_WIDTH-1:0] ctrl1_y_i,
  input  wire logic signed [COORD_WIDTH-1:0] ctrl2_x_i,
  input  wire logic signed [COORD_WIDTH-1:0] ctrl2_y_i,
  input  wire logic signed [COORD_WIDTH-1:0] ctrl3_x_i,
  input  wire logic signed [COORD_WIDTH-1:0] ctrl3_y_i,
  output logic                            empty,
  input  wire logic                       pop,
  output logic signed [COORD_WIDTH-1:0]   out_x_o,
  output logic signed [COORD_WIDTH-1:0]   out_y_o,
  output logic        [2:0]               point_index_o,
  output logic                            last_point_o
);

  bcs_pkg::bcs_link_t               q_link;
  bcs_pkg::bcs_link_t               e_link;
  logic [T_FRAC_BITS:0]             q_t;
  logic [8*COORD_WIDTH-1:0]         q_c;
  logic [8*COORD_WIDTH-1:0]         coords;
  logic                             q_pop;
  logic                             e_ready;
  logic [7*COORD_WIDTH-1:0]         seq_x;
  logic [7*COORD_WIDTH-1:0]         seq_y;

  assign coords = {ctrl3_y_i, ctrl3_x_i, ctrl2_y_i, ctrl2_x_i,
                   ctrl1_y_i, ctrl1_x_i, ctrl0_y_i, ctrl0_x_i};

  // Front: clamp t, classify the order, queue the transaction.
  bcs_front #(
    .COORD_WIDTH (COORD_WIDTH),
    .T_FRAC_BITS (T_FRAC_BITS)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push      (push),
    .full      (full),
    .func_i    (func_i),
    .param_t_i (param_t_i),
    .coords_i  (coords),
    .pop_i     (q_pop),
    .link_o    (q_link),
    .item_t_o  (q_t),
    .item_c_o  (q_c)
  );

  // Back: level-by-level subdivision.
  bcs_engine #(
    .COORD_WIDTH (COORD_WIDTH),
    .T_FRAC_BITS (T_FRAC_BITS)
  ) u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_link_i   (q_link),
    .item_t_i    (q_t),
    .item_c_i    (q_c),
    .pop_o       (q_pop),
    .out_link_o  (e_link),
    .out_ready_i (e_ready),
    .seq_x_o     (seq_x),
    .seq_y_o     (seq_y)
  );

  // Result port: one split point per pop transaction.
  bcs_emit #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_emit (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_link_i     (e_link),
    .ready_o       (e_ready),
    .seq_x_i       (seq_x),
    .seq_y_i       (seq_y),
    .empty         (empty),
    .pop           (pop),
    .out_x_o       (out_x_o),
    .out_y_o       (out_y_o),
    .point_index_o (point_index_o),
    .last_point_o  (last_point_o)
  );

endmodule

`default_nettype wire

// ===== tb/sv/bezier_curve_split_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the de Casteljau Bezier curve splitter.
// Depends on bcs_pkg and bezier_curve_split; predicts every split point in place.

module bezier_curve_split_tb;

  localparam int CW = 32;
  localparam int TF = 16;
  localparam longint T_ONE = longint'(1) << TF;
  localparam int RANDOM_CURVES = 297;

  typedef logic [3:0][CW-1:0] ctrl_set_t;
  typedef logic [6:0][CW-1:0] axis_seq_t;

  // One input transaction: curve order, split parameter and control points.
  typedef struct packed {
    logic          func;
    logic [TF:0]   t;
    ctrl_set_t     cx;
    ctrl_set_t     cy;
  } curve_t;

  // One result transaction: a split control point with its position.
  typedef struct packed {
    logic [CW-1:0] x;
    logic [CW-1:0] y;
    logic [2:0]    idx;
    logic          last;
  } split_point_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic push = 1'b0;
  logic pop = 1'b0;
  curve_t drv_curve = '0;

  logic full;
  logic empty;
  logic signed [CW-1:0] out_x;
  logic signed [CW-1:0] out_y;
  logic [2:0] point_index;
  logic last_point;

  curve_t pending_curves[$];
  split_point_t split_points_q[$];

  logic curve_accepted = 1'b0;
  logic point_taken = 1'b0;
  int send_gap = 0;
  int hold_left = 0;
  int sent_count = 0;
  int popped_count = 0;
  int curves_accepted = 0;
  int total_curves = 0;
  int mismatch_count = 0;

  bezier_curve_split dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push          (push),
    .full          (full),
    .func_i        (drv_curve.func),
    .param_t_i     (drv_curve.t),
    .ctrl0_x_i     (drv_curve.cx[0]),
    .ctrl0_y_i     (drv_curve.cy[0]),
    .ctrl1_x_i     (drv_curve.cx[1]),
    .ctrl1_y_i     (drv_curve.cy[1]),
    .ctrl2_x_i     (drv_curve.cx[2]),
    .ctrl2_y_i     (drv_curve.cy[2]),
    .ctrl3_x_i     (drv_curve.cx[3]),
    .ctrl3_y_i     (drv_curve.cy[3]),
    .empty         (empty),
    .pop           (pop),
    .out_x_o       (out_x),
    .out_y_o       (out_y),
    .point_index_o (point_index),
    .last_point_o  (last_point)
  );

  // Linear blend a + (b - a) * t, rounded to nearest with ties toward plus infinity.
  function automatic longint lerp_round(longint a, longint b, longint t);
    longint prod;
    prod = (b - a) * t + (longint'(1) << (TF - 1));
    return a + (prod >>> TF);
  endfunction

  // Split one coordinate axis; unused tail entries stay zero for a quadratic curve.
  function automatic axis_seq_t split_axis(longint p0, longint p1, longint p2, longint p3,
                                           logic cubic, longint t);
    axis_seq_t s;
    longint ab, bc, cd, abc, bcd;
    s = '0;
    ab = lerp_round(p0, p1, t);
    bc = lerp_round(p1, p2, t);
    s[0] = CW'(p0);
    s[1] = CW'(ab);
    if (cubic) begin
      cd = lerp_round(p2, p3, t);
      abc = lerp_round(ab, bc, t);
      bcd = lerp_round(bc, cd, t);
      s[2] = CW'(abc);
      s[3] = CW'(lerp_round(abc, bcd, t));
      s[4] = CW'(bcd);
      s[5] = CW'(cd);
      s[6] = CW'(p3);
    end else begin
      s[2] = CW'(lerp_round(ab, bc, t));
      s[3] = CW'(bc);
      s[4] = CW'(p2);
    end
    return s;
  endfunction

  // Queue the split points that one accepted curve must produce.
  function automatic void predict_split(curve_t c);
    axis_seq_t xs, ys;
    longint t;
    int n;
    split_point_t p;
    t = (longint'(c.t) > T_ONE) ? T_ONE : longint'(c.t);
    xs = split_axis(longint'($signed(c.cx[0])), longint'($signed(c.cx[1])),
                    longint'($signed(c.cx[2])), longint'($signed(c.cx[3])),
                    c.func == bcs_pkg::FUNC_CUBIC, t);
    ys = split_axis(longint'($signed(c.cy[0])), longint'($signed(c.cy[1])),
                    longint'($signed(c.cy[2])), longint'($signed(c.cy[3])),
                    c.func == bcs_pkg::FUNC_CUBIC, t);
    n = (c.func == bcs_pkg::FUNC_CUBIC) ? int'(bcs_pkg::LAST_IDX_CUBIC) + 1
                                        : int'(bcs_pkg::LAST_IDX_QUAD) + 1;
    for (int k = 0; k < n; k++) begin
      p.x = xs[k];
      p.y = ys[k];
      p.idx = 3'(k);
      p.last = (k == n - 1);
      split_points_q.push_back(p);
    end
  endfunction

  function automatic void check_field(string what, logic [CW-1:0] want, logic [CW-1:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, what, want, got);
      mismatch_count++;
    end
  endfunction

  // Wait length per transaction; phases of no waiting, heavy waiting and light waiting.
  function automatic int draw_wait(int n);
    case ((n / 24) % 3)
      0: return 0;
      1: return $urandom_range(0, 18);
      default: return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 18) : 0;
    endcase
  endfunction

  function automatic logic [CW-1:0] rand_coord();
    case ($urandom_range(0, 5))
      0, 1, 2: return CW'($urandom);
      3: return CW'(int'($urandom_range(0, 4095)) - 2048);
      4: return CW'(int'($urandom_range(0, 1 << 20)) - (1 << 19));
      default: begin
        case ($urandom_range(0, 3))
          0: return {1'b1, {(CW - 1){1'b0}}};
          1: return {1'b0, {(CW - 1){1'b1}}};
          2: return '0;
          default: return '1;
        endcase
      end
    endcase
  endfunction

  function automatic logic [TF:0] rand_param_t();
    case ($urandom_range(0, 9))
      0: return (TF + 1)'($urandom_range(int'(T_ONE) + 1, (2 * int'(T_ONE)) - 1));
      1: begin
        case ($urandom_range(0, 4))
          0: return '0;
          1: return (TF + 1)'(1);
          2: return (TF + 1)'(T_ONE >> 1);
          3: return (TF + 1)'(T_ONE - 1);
          default: return (TF + 1)'(T_ONE);
        endcase
      end
      default: return (TF + 1)'($urandom_range(0, int'(T_ONE)));
    endcase
  endfunction

  function automatic void add_curve(logic f, logic [TF:0] t, ctrl_set_t xs, ctrl_set_t ys);
    curve_t c;
    c.func = f;
    c.t = t;
    c.cx = xs;
    c.cy = ys;
    pending_curves.push_back(c);
    total_curves++;
  endfunction

  // Clock and a single reset pulse at the start.
  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
  end

  // Driver: presents the next pending curve, holding it until the transaction completes.
  always @(negedge clk_i) begin : driver
    if (rst_ni) begin
      if (!push || curve_accepted) begin
        if (send_gap > 0) begin
          send_gap--;
          push <= 1'b0;
        end else if (pending_curves.size() != 0) begin
          drv_curve <= pending_curves.pop_front();
          push <= 1'b1;
          send_gap = draw_wait(sent_count);
          sent_count++;
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  // Result side: after each popped point, hold pop low for a wait drawn per point.
  always @(negedge clk_i) begin : sink
    if (rst_ni) begin
      if (point_taken) begin
        hold_left = draw_wait(popped_count);
        popped_count++;
      end
      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  // Monitor: records accepted curves and checks each popped point against the oldest prediction.
  always @(posedge clk_i) begin : monitor
    split_point_t want;
    curve_accepted <= rst_ni && push && !full;
    point_taken <= rst_ni && pop && !empty;
    if (rst_ni && push && !full) begin
      predict_split(drv_curve);
      curves_accepted++;
    end
    if (rst_ni && pop && !empty) begin
      if (split_points_q.size() == 0) begin
        $display("%0t: unexpected point, expected none actual x=%0h y=%0h index=%0d last=%0b",
                 $time, out_x, out_y, point_index, last_point);
        mismatch_count++;
      end else begin
        want = split_points_q.pop_front();
        check_field("out_x", want.x, out_x);
        check_field("out_y", want.y, out_y);
        check_field("point_index", CW'(want.idx), CW'(point_index));
        check_field("last_point", CW'(want.last), CW'(last_point));
      end
    end
  end

  // Stimulus: directed corner curves first, then random curves; then drain and report.
  initial begin : stimulus
    ctrl_set_t xs, ys;
    logic [CW-1:0] cmin, cmax;
    cmin = {1'b1, {(CW - 1){1'b0}}};
    cmax = {1'b0, {(CW - 1){1'b1}}};

    // Parameter at both ends of the range and above one.
    for (int k = 0; k < 8; k++) begin
      for (int j = 0; j < 4; j++) begin
        xs[j] = rand_coord();
        ys[j] = rand_coord();
      end
      case (k)
        0: add_curve(bcs_pkg::FUNC_QUAD, '0, xs, ys);
        1: add_curve(bcs_pkg::FUNC_QUAD, (TF + 1)'(T_ONE), xs, ys);
        2: add_curve(bcs_pkg::FUNC_CUBIC, '0, xs, ys);
        3: add_curve(bcs_pkg::FUNC_CUBIC, (TF + 1)'(T_ONE), xs, ys);
        4: add_curve(bcs_pkg::FUNC_CUBIC, '1, xs, ys);
        5: add_curve(bcs_pkg::FUNC_QUAD, (TF + 1)'(T_ONE + 1), xs, ys);
        6: add_curve(bcs_pkg::FUNC_QUAD, '1, xs, ys);
        default: add_curve(bcs_pkg::FUNC_CUBIC, (TF + 1)'(1), xs, ys);
      endcase
    end

    // Exact halves: steps of one LSB at t = 0.5 land on rounding ties.
    add_curve(bcs_pkg::FUNC_CUBIC, (TF + 1)'(T_ONE >> 1), {CW'(1), CW'(0), CW'(1), CW'(0)},
              {CW'(-1), CW'(0), CW'(-1), CW'(0)});
    add_curve(bcs_pkg::FUNC_QUAD, (TF + 1)'(T_ONE >> 1), {CW'(5), CW'(-1), CW'(0), CW'(-1)},
              {CW'(0), CW'(1), CW'(0), CW'(3)});

    // Coordinate extremes: alternating sets whose differences span the full range, plus mixed and constant sets.
    add_curve(bcs_pkg::FUNC_CUBIC, (TF + 1)'(T_ONE >> 1), {cmax, cmin, cmax, cmin},
              {cmin, cmax, cmin, cmax});
    add_curve(bcs_pkg::FUNC_CUBIC, (TF + 1)'(T_ONE - 1), {cmin, cmax, cmin, cmax},
              {cmax, cmin, cmax, cmin});
    add_curve(bcs_pkg::FUNC_QUAD, (TF + 1)'(1), {cmax, cmax, cmin, cmax},
              {cmin, cmin, cmax, cmin});
    add_curve(bcs_pkg::FUNC_QUAD, (TF + 1)'(T_ONE - 1), {cmin, cmax, cmax, cmin},
              {cmax, cmin, cmin, cmax});
    add_curve(bcs_pkg::FUNC_CUBIC, (TF + 1)'(3), {cmax, cmax, cmax, cmax},
              {cmin, cmin, cmin, cmin});

    // Random curves of both orders.
    for (int k = 0; k < RANDOM_CURVES; k++) begin
      for (int j = 0; j < 4; j++) begin
        xs[j] = rand_coord();
        ys[j] = rand_coord();
      end
      add_curve($urandom_range(0, 1) ? bcs_pkg::FUNC_CUBIC : bcs_pkg::FUNC_QUAD,
                rand_param_t(), xs, ys);
    end

    while (curves_accepted != total_curves) @(negedge clk_i);
    while (split_points_q.size() != 0) @(negedge clk_i);
    repeat (30) @(posedge clk_i);
    if (mismatch_count == 0)
      $display("[bezier_curve_split] OK");
    else
      $display("[bezier_curve_split] ERROR");
    $finish;
  end

  // Watchdog for a run that hangs.
  initial begin
    #5_000_000;
    $display("[bezier_curve_split] ERROR");
    $finish;
  end

endmodule
